/* hw/rtl/rpdh_pkg.sv */
`default_nettype none
package rpdh_pkg;

    localparam int unsigned MAX_BINS_LOG2_DEF = 10;
    localparam int unsigned COUNT_WIDTH_DEF   = 32;

    // width of an effective bins_log2 value (holds up to 31)
    localparam int unsigned K_W = 5;

    localparam logic [3:0] BINS_LOG2_RST = 4'd10;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

endpackage
`default_nettype wire

/* hw/rtl/rpdh_div.sv */
`default_nettype none
module rpdh_div #(
    parameter int unsigned Q_W = rpdh_pkg::MAX_BINS_LOG2_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [31:0]              i_num,
    input  wire logic [31:0]              i_den,
    input  wire logic [rpdh_pkg::K_W-1:0] i_k,
    output logic                          o_done,
    output logic [Q_W-1:0]                o_quot
);

    logic                     r_run;
    logic                     r_done;
    logic [rpdh_pkg::K_W-1:0] r_cnt;
    logic [31:0]              r_rem;
    logic [31:0]              r_den;
    logic [Q_W-1:0]           r_quot;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        q_bit;
    logic [31:0] n_rem;
    logic [Q_W-1:0] n_quot;

    // one restoring step per cycle: quotient bit of 2*rem against den
    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        q_bit   = ~diff[32];
        n_rem   = q_bit ? diff[31:0] : shifted[31:0];
        n_quot  = Q_W'({r_quot, q_bit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= i_k;
            end else if (r_run) begin
                r_cnt <= r_cnt - rpdh_pkg::K_W'(1);
                if (r_cnt == rpdh_pkg::K_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_run) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

/* hw/rtl/rpdh_mem.sv */
`default_nettype none
module rpdh_mem #(
    parameter int unsigned ADDR_W = rpdh_pkg::MAX_BINS_LOG2_DEF,
    parameter int unsigned DATA_W = rpdh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0]      o_rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/rational_point_dyadic_histogram_top.sv */
// Add: the restoring divider yields k quotient bits (k = clamped bins_log2), one per cycle,
//   then a read-modify-write of the store through S_RDA (split only), S_RDB and S_WRB.
// Read: strobe 3 cycles after accept. Rejected add and unused command: strobe next cycle.
// Clear: one store row per cycle, strobe 2^MAX_BINS_LOG2 + 1 cycles after accept.
// Reset: a clearing pass over all 2^MAX_BINS_LOG2 store rows with busy high; results are always taken.
// A new item is accepted in the cycle its predecessor's result is strobed.
`default_nettype none
module rational_point_dyadic_histogram_top #(
    parameter int unsigned MAX_BINS_LOG2 = rpdh_pkg::MAX_BINS_LOG2_DEF,
    parameter int unsigned COUNT_WIDTH   = rpdh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_numerator,
    input  wire logic [31:0] i_denominator,
    input  wire logic [9:0]  i_read_index,
    output logic             o_valid,
    output logic [9:0]       o_bin_index,
    output logic             o_was_split,
    output logic [31:0]      o_count_halves,
    output logic             o_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned A_W = MAX_BINS_LOG2;
    localparam int unsigned C_W = COUNT_WIDTH;
    localparam int unsigned K_W = rpdh_pkg::K_W;

    localparam logic [A_W-1:0] LP_ONES    = '1;
    localparam logic [C_W-1:0] LP_OUT_MAX = C_W'(33'h0_FFFF_FFFF);
    localparam logic [C_W-1:0] LP_TWO     = C_W'(2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_WRB  = 3'd5;
    localparam logic [2:0] S_RDO  = 3'd6;

    function automatic logic [K_W-1:0] eff_k(input logic [3:0] v);
        logic [K_W-1:0] kv;
        kv = K_W'(v);
        if (kv == '0) begin
            kv = K_W'(1);
        end else if (kv > K_W'(MAX_BINS_LOG2)) begin
            kv = K_W'(MAX_BINS_LOG2);
        end
        return kv;
    endfunction

    function automatic logic [C_W-1:0] sat_inc(input logic [C_W-1:0] c, input logic [1:0] inc);
        logic [C_W:0] sum;
        sum = {1'b0, c} + (C_W + 1)'(inc);
        return sum[C_W] ? {C_W{1'b1}} : sum[C_W-1:0];
    endfunction

    // control registers
    logic [2:0]     r_state, n_state;
    logic           r_clr_cmd, n_clr_cmd;
    logic           r_valid, n_valid;
    logic [3:0]     r_bins_log2;

    // payload registers
    logic [1:0]     r_cmd, n_cmd;
    logic           r_split, n_split;
    logic [A_W-1:0] r_b, n_b;
    logic [A_W-1:0] r_ptr, n_ptr;
    logic [A_W-1:0] r_last, n_last;
    logic [9:0]     r_o_bin, n_o_bin;
    logic           r_o_split, n_o_split;
    logic [31:0]    r_o_count, n_o_count;
    logic           r_o_status, n_o_status;

    logic           accept;
    logic           cfg_wr;
    logic [K_W-1:0] k_eff;
    logic [31:0]    d_m1;
    logic           bad_frac;
    logic           pow2;
    logic           div_start;
    logic           div_done;
    logic [A_W-1:0] div_quot;

    logic           mem_we;
    logic [A_W-1:0] mem_waddr;
    logic [C_W-1:0] mem_wdata;
    logic [A_W-1:0] mem_raddr;
    logic [C_W-1:0] mem_rdata;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_bins_log2};

    always_comb begin
        k_eff     = eff_k(r_bins_log2);
        d_m1      = i_denominator - 32'd1;
        bad_frac  = (i_numerator == 32'd0) || (i_numerator >= i_denominator);
        pow2      = ((i_denominator & d_m1) == 32'd0)
                 && ({1'b0, i_denominator} <= (33'd1 << k_eff));
        div_start = accept && (i_cmd == rpdh_pkg::CMD_ADD) && !bad_frac;
    end

    rpdh_div #(
        .Q_W(A_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_numerator),
        .i_den   (i_denominator),
        .i_k     (k_eff),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    rpdh_mem #(
        .ADDR_W(A_W),
        .DATA_W(C_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // store port steering
    always_comb begin
        mem_raddr = (r_state == S_RDA) ? (r_b - A_W'(1)) : r_b;
        mem_we    = 1'b0;
        mem_waddr = r_b;
        mem_wdata = sat_inc(mem_rdata, r_split ? 2'd1 : 2'd2);
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = ((r_ptr == '0) || (r_ptr == r_last)) ? LP_TWO : '0;
            end
            S_RDB: begin
                // lower bin of a split: its count was read in the previous cycle
                mem_we    = r_split && (r_cmd == rpdh_pkg::CMD_ADD);
                mem_waddr = r_b - A_W'(1);
                mem_wdata = sat_inc(mem_rdata, 2'd1);
            end
            S_WRB: begin
                mem_we    = 1'b1;
                mem_waddr = r_b;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_cmd  = r_clr_cmd;
        n_valid    = 1'b0;
        n_cmd      = r_cmd;
        n_split    = r_split;
        n_b        = r_b;
        n_ptr      = r_ptr;
        n_last     = r_last;
        n_o_bin    = r_o_bin;
        n_o_split  = r_o_split;
        n_o_count  = r_o_count;
        n_o_status = r_o_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    case (i_cmd)
                        rpdh_pkg::CMD_ADD: begin
                            if (bad_frac) begin
                                n_valid    = 1'b1;
                                n_o_bin    = '0;
                                n_o_split  = 1'b0;
                                n_o_count  = '0;
                                n_o_status = 1'b1;
                            end else begin
                                n_split = pow2;
                                n_state = S_DIV;
                            end
                        end
                        rpdh_pkg::CMD_READ: begin
                            n_split = 1'b0;
                            n_b     = A_W'(i_read_index);
                            n_state = S_RDB;
                        end
                        rpdh_pkg::CMD_CLEAR: begin
                            n_ptr     = '0;
                            n_last    = ~(LP_ONES << k_eff);
                            n_clr_cmd = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_valid    = 1'b1;
                            n_o_bin    = '0;
                            n_o_split  = 1'b0;
                            n_o_count  = '0;
                            n_o_status = 1'b0;
                        end
                    endcase
                end
            end
            S_CLR: begin
                n_ptr = r_ptr + A_W'(1);
                if (r_ptr == LP_ONES) begin
                    n_state    = S_IDLE;
                    n_clr_cmd  = 1'b0;
                    n_valid    = r_clr_cmd;
                    n_o_bin    = '0;
                    n_o_split  = 1'b0;
                    n_o_count  = '0;
                    n_o_status = 1'b0;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_b     = div_quot;
                    n_state = r_split ? S_RDA : S_RDB;
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                n_state = (r_cmd == rpdh_pkg::CMD_READ) ? S_RDO : S_WRB;
            end
            S_WRB: begin
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_o_bin    = 10'(r_b);
                n_o_split  = r_split;
                n_o_count  = '0;
                n_o_status = 1'b0;
            end
            S_RDO: begin
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_o_bin    = '0;
                n_o_split  = 1'b0;
                n_o_count  = (mem_rdata > LP_OUT_MAX) ? 32'hFFFF_FFFF : 32'(mem_rdata);
                n_o_status = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // sweep the store to its initial contents before taking items
            r_state     <= S_CLR;
            r_clr_cmd   <= 1'b0;
            r_valid     <= 1'b0;
            r_bins_log2 <= rpdh_pkg::BINS_LOG2_RST;
            r_ptr       <= '0;
            r_last      <= ~(LP_ONES << eff_k(rpdh_pkg::BINS_LOG2_RST));
        end else begin
            r_state   <= n_state;
            r_clr_cmd <= n_clr_cmd;
            r_valid   <= n_valid;
            r_ptr     <= n_ptr;
            r_last    <= n_last;
            if (cfg_wr && !paddr[2]) begin
                r_bins_log2 <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_split    <= n_split;
        r_b        <= n_b;
        r_o_bin    <= n_o_bin;
        r_o_split  <= n_o_split;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
    end

    assign o_valid        = r_valid;
    assign o_bin_index    = r_o_bin;
    assign o_was_split    = r_o_split;
    assign o_count_halves = r_o_count;
    assign o_status       = r_o_status;

`ifndef ASSERT_OFF
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted item neither in work nor finished");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_split_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_split) |-> (!o_status && (o_count_halves == 32'd0)))
        else $error("split result carries status or count");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_CLR) || (r_state == S_RDB) || (r_state == S_WRB)))
        else $error("store written outside clear or update");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] CMD_UNUSED         = 2'd3;
    localparam logic [2:0] REG_BINS_LOG2_ADDR = 3'd0;
    localparam int unsigned NUM_PHASES   = 9;
    localparam int unsigned PHASE_ITEMS  = 180;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned STORE_DEPTH  = 1 << rpdh_pkg::MAX_BINS_LOG2_DEF;
    localparam int unsigned PHASE_BINS_LOG2 [NUM_PHASES] = '{10, 1, 0, 15, 4, 7, 2, 11, 10};
    localparam int unsigned PHASE_IDLE_PCT  [NUM_PHASES] = '{0, 69, 35, 0, 69, 35, 0, 69, 35};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] numerator;
        logic [31:0] denominator;
        logic [9:0]  read_index;
    } t_hist_item;

    typedef struct packed {
        logic [9:0]  bin_index;
        logic        was_split;
        logic [31:0] count_halves;
        logic        status;
    } t_hist_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  i_cmd          = '0;
    logic [31:0] i_numerator    = '0;
    logic [31:0] i_denominator  = '0;
    logic [9:0]  i_read_index   = '0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic        busy;
    logic        o_valid;
    logic [9:0]  o_bin_index;
    logic        o_was_split;
    logic [31:0] o_count_halves;
    logic        o_status;
    logic [31:0] prdata;
    logic        pready;

    rational_point_dyadic_histogram_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_numerator    (i_numerator),
        .i_denominator  (i_denominator),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .o_bin_index    (o_bin_index),
        .o_was_split    (o_was_split),
        .o_count_halves (o_count_halves),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- histogram predictor ----------------
    logic [31:0]  bin_halves [STORE_DEPTH];
    logic [3:0]   bins_log2_reg;

    t_hist_item   item_pending [$];
    t_hist_result expected_results [$];
    t_hist_item   next_item;
    logic         item_taken = 1'b0;
    int unsigned  idle_pct = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  stall_cycles = 0;
    int unsigned  n_adds = 0, n_splits = 0, n_rejects = 0;
    int unsigned  n_reads = 0, n_clears = 0, n_unused = 0;

    function automatic int unsigned active_k();
        if (bins_log2_reg < 4'd1) return 1;
        if (bins_log2_reg > rpdh_pkg::MAX_BINS_LOG2_DEF) return rpdh_pkg::MAX_BINS_LOG2_DEF;
        return bins_log2_reg;
    endfunction

    function automatic void restore_bins();
        int unsigned last;
        last = (1 << active_k()) - 1;
        foreach (bin_halves[i]) bin_halves[i] = '0;
        bin_halves[0] = 32'd2;
        bin_halves[last % STORE_DEPTH] = 32'd2;
    endfunction

    // saturate at the top of the count range
    function automatic void bump_bin(logic [9:0] idx, logic [31:0] inc);
        if (32'hFFFF_FFFF - bin_halves[idx] < inc) bin_halves[idx] = 32'hFFFF_FFFF;
        else bin_halves[idx] = bin_halves[idx] + inc;
    endfunction

    function automatic t_hist_result histogram_step(t_hist_item it);
        t_hist_result r;
        int unsigned  k;
        logic [47:0]  bin_q;
        logic [31:0]  d;
        r = '0;
        k = active_k();
        d = it.denominator;
        case (it.cmd)
            rpdh_pkg::CMD_ADD: begin
                if (it.numerator == 32'd0 || it.numerator >= d) begin
                    r.status = 1'b1;
                end else begin
                    bin_q = ({16'd0, it.numerator} << k) / {16'd0, d};
                    // dyadic point: lies on the boundary between two bins
                    if ((d & (d - 32'd1)) == 32'd0 && d <= (32'd1 << k)) begin
                        bump_bin(bin_q[9:0] - 10'd1, 32'd1);
                        bump_bin(bin_q[9:0], 32'd1);
                        r.was_split = 1'b1;
                    end else begin
                        bump_bin(bin_q[9:0], 32'd2);
                    end
                    r.bin_index = bin_q[9:0];
                end
            end
            rpdh_pkg::CMD_READ:  r.count_halves = bin_halves[it.read_index];
            rpdh_pkg::CMD_CLEAR: restore_bins();
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic t_hist_item make_item(logic [1:0] cmd, logic [31:0] n, logic [31:0] d,
                                             logic [9:0] idx);
        t_hist_item it;
        it.cmd = cmd;
        it.numerator = n;
        it.denominator = d;
        it.read_index = idx;
        return it;
    endfunction

    function automatic t_hist_item random_item(int unsigned k);
        t_hist_item  it;
        int unsigned sel;
        int unsigned j;
        logic [31:0] d;
        it = make_item(rpdh_pkg::CMD_ADD, $urandom, $urandom, 10'($urandom));
        sel = $urandom_range(99);
        if (sel < 20) begin
            // dyadic denominators, mostly near the split limit
            if ($urandom_range(99) < 85) j = $urandom_range((k + 2 > 31) ? 31 : k + 2, 1);
            else j = $urandom_range(31, 1);
            d = 32'd1 << j;
            it.denominator = d;
            it.numerator = $urandom_range(d - 32'd1, 1);
        end else if (sel < 42) begin
            d = $urandom_range(3000, 2);
            it.denominator = d;
            it.numerator = $urandom_range(d - 32'd1, 1);
        end else if (sel < 55) begin
            d = $urandom;
            if (d < 32'd2) d = 32'd2;
            it.denominator = d;
            it.numerator = $urandom_range(d - 32'd1, 1);
        end else if (sel < 61) begin
            // rejected fractions
            case ($urandom_range(3))
                0: it.numerator = 32'd0;
                1: it.numerator = it.denominator;
                2: it.denominator = 32'd0;
                default: it.numerator = $urandom_range(32'hFFFF_FFFF, it.denominator);
            endcase
        end else if (sel < 93) begin
            it.cmd = rpdh_pkg::CMD_READ;
            if ($urandom_range(99) < 75) it.read_index = 10'($urandom_range((1 << k) - 1));
        end else if (sel < 95) begin
            it.cmd = rpdh_pkg::CMD_CLEAR;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    task automatic wait_drained();
        while (item_pending.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BINS_LOG2_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [3:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_BINS_LOG2_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== {28'd0, want})
            note_mismatch($sformatf("bins_log2 readback: expected %0d, got %0h", want, got));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        if (start && !item_taken) begin
            // hold the item until it is taken
        end else if (item_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_item = item_pending.pop_front();
            start         <= 1'b1;
            i_cmd         <= next_item.cmd;
            i_numerator   <= next_item.numerator;
            i_denominator <= next_item.denominator;
            i_read_index  <= next_item.read_index;
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    t_hist_result seen, want_r;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                seen = '{o_bin_index, o_was_split, o_count_halves, o_status};
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected item: bin %0d split %0b count %0d st %0b",
                                            seen.bin_index, seen.was_split,
                                            seen.count_halves, seen.status));
                end else begin
                    want_r = expected_results.pop_front();
                    if (seen.bin_index !== want_r.bin_index || seen.was_split !== want_r.was_split
                        || seen.count_halves !== want_r.count_halves
                        || seen.status !== want_r.status)
                        note_mismatch($sformatf(
                            "expected bin %0d split %0b count %0d st %0b, got %0d %0b %0d %0b",
                            want_r.bin_index, want_r.was_split, want_r.count_halves, want_r.status,
                            seen.bin_index, seen.was_split, seen.count_halves, seen.status));
                end
            end
            if (start && !busy) begin
                want_r = histogram_step(make_item(i_cmd, i_numerator, i_denominator, i_read_index));
                expected_results.push_back(want_r);
                case (i_cmd)
                    rpdh_pkg::CMD_ADD: begin
                        if (want_r.status) n_rejects++;
                        else n_adds++;
                        if (want_r.was_split) n_splits++;
                    end
                    rpdh_pkg::CMD_READ:  n_reads++;
                    rpdh_pkg::CMD_CLEAR: n_clears++;
                    default:   n_unused++;
                endcase
            end
        end
        item_taken <= i_rst_n && start && !busy;
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        logic [3:0]  k_val;
        logic [31:0] wdata;
        bins_log2_reg = rpdh_pkg::BINS_LOG2_RST;
        restore_bins();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(rpdh_pkg::BINS_LOG2_RST);

        // directed: end bins, dyadic splits, widest fields, rejects, unused command, clear
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         10'd1023));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1, 32'd2, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1, 32'd1024, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1023, 32'd1024, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1, 32'd2048, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd3, 32'd6, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                                         10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1, 32'hFFFF_FFFF, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF,
                                         10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd1, 32'd3, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd0, 32'd5, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'd5, 32'd0, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000,
                                         10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd1));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd511));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd512));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd341));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd1023));
        item_pending.push_back(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF));
        item_pending.push_back(make_item(rpdh_pkg::CMD_CLEAR, 32'd7, 32'd9, 10'd5));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd0));
        item_pending.push_back(make_item(rpdh_pkg::CMD_READ, 32'd0, 32'd0, 10'd512));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                k_val = 4'(PHASE_BINS_LOG2[ph]);
                // upper data bits are don't-care for a 4-bit register
                wdata = ($urandom & 32'hFFFF_FFF0) | {28'd0, k_val};
                apb_write(wdata);
                bins_log2_reg = k_val;
                apb_read_check(k_val);
            end
            idle_pct = PHASE_IDLE_PCT[ph];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // at the halfway item, the sender holds off until the block has drained
                if (i == PHASE_ITEMS / 2) wait_drained();
                item_pending.push_back(random_item(active_k()));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d adds (%0d split), %0d rejected, %0d reads, %0d clears, %0d unused",
                 n_adds, n_splits, n_rejects, n_reads, n_clears, n_unused);
        $display("over %0d bins_log2 settings incl. clamped extremes; %0d mismatches",
                 NUM_PHASES, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
